@@ rtl/clni_pkg.sv @@
package clni_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 256;
    localparam int unsigned WAIT_W              = 16;
    localparam int unsigned CFG_INDEX_W         = 3;
    localparam int unsigned CFG_DATA_W          = 16;
    localparam int unsigned FLAGS_W             = 4;

    localparam logic [WAIT_W-1:0]  POWER_UP_WAIT_RST    = 16'd50000;
    localparam logic [WAIT_W-1:0]  INIT_NIBBLE_WAIT_RST = 16'd6000;
    localparam logic [WAIT_W-1:0]  INIT_FINAL_WAIT_RST  = 16'd150;
    localparam logic [WAIT_W-1:0]  SHORT_WAIT_RST       = 16'd50;
    localparam logic [WAIT_W-1:0]  LONG_CMD_WAIT_RST    = 16'd1400;
    localparam logic [FLAGS_W-1:0] FUNCTION_FLAGS_RST   = 4'd8;

    localparam logic [3:0] NIBBLE_WAKE   = 4'h3;
    localparam logic [3:0] NIBBLE_4BIT   = 4'h2;
    localparam logic [3:0] CMD_FUNC_HIGH = 4'h2;
    localparam logic [7:0] CMD_DISPLAY   = 8'h0C;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;

    localparam logic [1:0] INIT_REPEATS_LAST = 2'd3;
    localparam logic [1:0] INIT_CMD_LAST     = 2'd3;

    typedef enum logic
    {
        OP_TICK    = 1'b0,
        OP_ENQUEUE = 1'b1
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        CFG_POWER_UP_WAIT    = 3'd0,
        CFG_INIT_NIBBLE_WAIT = 3'd1,
        CFG_INIT_FINAL_WAIT  = 3'd2,
        CFG_SHORT_WAIT       = 3'd3,
        CFG_LONG_CMD_WAIT    = 3'd4,
        CFG_FUNCTION_FLAGS   = 3'd5
    } cfg_index_t;

    typedef enum logic [6:0]
    {
        PH_PWR      = 7'b000_0001,
        PH_NIB_WAIT = 7'b000_0010,
        PH_NIB_HI   = 7'b000_0100,
        PH_CMD_GAP  = 7'b000_1000,
        PH_CMD_SEND = 7'b001_0000,
        PH_Q_WAIT   = 7'b010_0000,
        PH_Q_SEND   = 7'b100_0000
    } phase_t;

    typedef struct packed
    {
        logic       long_wait;
        logic       is_data;
        logic [7:0] value;
    } entry_t;

    typedef struct packed
    {
        logic [WAIT_W-1:0]  power_up_wait;
        logic [WAIT_W-1:0]  init_nibble_wait;
        logic [WAIT_W-1:0]  init_final_wait;
        logic [WAIT_W-1:0]  short_wait;
        logic [WAIT_W-1:0]  long_cmd_wait;
        logic [FLAGS_W-1:0] function_flags;
    } cfg_t;

    typedef struct packed
    {
        logic empty;
        logic full;
        logic full_next;
    } fifo_status_t;

    typedef struct packed
    {
        logic       reg_select;
        logic       enable_pin;
        logic [3:0] data_nibble;
        logic       init_done;
        logic       pop;
    } seq_out_t;

    function automatic entry_t init_command(input logic [1:0] idx,
                                            input logic [FLAGS_W-1:0] flags);
        entry_t cmd;
        cmd = '0;
        unique case (idx)
            2'd0:
            begin
                cmd.value = {CMD_FUNC_HIGH, flags};
            end
            2'd1:
            begin
                cmd.value = CMD_DISPLAY;
            end
            2'd2:
            begin
                cmd.value     = CMD_CLEAR;
                cmd.long_wait = 1'b1;
            end
            default:
            begin
                cmd.value = CMD_ENTRY;
            end
        endcase
        return cmd;
    endfunction

endpackage

@@ rtl/clni_cfg.sv @@
module clni_cfg
    import clni_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_POWER_UP_WAIT:    cfg_next.power_up_wait    = cfg_data;
                CFG_INIT_NIBBLE_WAIT: cfg_next.init_nibble_wait = cfg_data;
                CFG_INIT_FINAL_WAIT:  cfg_next.init_final_wait  = cfg_data;
                CFG_SHORT_WAIT:       cfg_next.short_wait       = cfg_data;
                CFG_LONG_CMD_WAIT:    cfg_next.long_cmd_wait    = cfg_data;
                CFG_FUNCTION_FLAGS:   cfg_next.function_flags   = cfg_data[FLAGS_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_up_wait    <= POWER_UP_WAIT_RST;
            cfg_reg.init_nibble_wait <= INIT_NIBBLE_WAIT_RST;
            cfg_reg.init_final_wait  <= INIT_FINAL_WAIT_RST;
            cfg_reg.short_wait       <= SHORT_WAIT_RST;
            cfg_reg.long_cmd_wait    <= LONG_CMD_WAIT_RST;
            cfg_reg.function_flags   <= FUNCTION_FLAGS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/clni_fifo.sv @@
module clni_fifo
    import clni_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  entry_t       wdata,
    input  logic         pop,
    output entry_t       head,
    output fifo_status_t status
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(QUEUE_DEPTH);

    entry_t mem [QUEUE_DEPTH];

    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    entry_t        head_reg;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        else if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // The head register always holds the entry at the next read pointer; a write
    // into an empty queue goes straight to it.
    always_ff @(posedge clk)
    begin
        if (push && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= wdata;
        end
        else
        begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    assign head             = head_reg;
    assign status.empty     = (count_reg == '0);
    assign status.full      = (count_reg == COUNT_FULL);
    assign status.full_next = (count_next == COUNT_FULL);

endmodule

@@ rtl/clni_seq.sv @@
module clni_seq
    import clni_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  cfg_t     cfg,
    input  entry_t   head,
    input  logic     queue_empty,
    output seq_out_t result
);

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [WAIT_W-1:0]   wait_reg;
    logic [WAIT_W-1:0]   wait_next;
    logic [1:0]          repeats_reg;
    logic [1:0]          repeats_next;
    logic [1:0]          cmd_idx_reg;
    logic [1:0]          cmd_idx_next;
    logic [1:0]          nib_step_reg;
    logic [1:0]          nib_step_next;
    entry_t              entry_reg;
    entry_t              entry_next;
    logic                rs_reg;
    logic                rs_next;
    logic                en_reg;
    logic                en_next;
    logic [3:0]          d_reg;
    logic [3:0]          d_next;
    logic                send_go;
    logic [1:0]          send_step;
    logic                send_last;
    logic                pop;

    assign send_last = (nib_step_reg == 2'd3);

    always_comb
    begin
        phase_next    = phase_reg;
        wait_next     = wait_reg;
        repeats_next  = repeats_reg;
        cmd_idx_next  = cmd_idx_reg;
        nib_step_next = nib_step_reg;
        entry_next    = entry_reg;
        rs_next       = rs_reg;
        en_next       = en_reg;
        d_next        = d_reg;
        send_go       = 1'b0;
        send_step     = nib_step_reg;
        pop           = 1'b0;

        if (step)
        begin
            unique case (phase_reg)
                PH_PWR, PH_NIB_WAIT:
                begin
                    if (wait_reg != '0)
                    begin
                        wait_next = wait_reg - 1'b1;
                        en_next   = 1'b0;
                    end
                    else
                    begin
                        rs_next    = 1'b0;
                        d_next     = (repeats_reg == INIT_REPEATS_LAST) ? NIBBLE_4BIT
                                                                        : NIBBLE_WAKE;
                        en_next    = 1'b1;
                        phase_next = PH_NIB_HI;
                    end
                end
                PH_NIB_HI:
                begin
                    en_next = 1'b0;
                    if (repeats_reg != INIT_REPEATS_LAST)
                    begin
                        repeats_next = repeats_reg + 1'b1;
                        wait_next    = (repeats_reg == 2'd2) ? cfg.init_final_wait
                                                             : cfg.init_nibble_wait;
                        phase_next   = PH_NIB_WAIT;
                    end
                    else
                    begin
                        wait_next    = cfg.short_wait;
                        cmd_idx_next = '0;
                        phase_next   = PH_CMD_GAP;
                    end
                end
                PH_CMD_GAP:
                begin
                    if (wait_reg != '0)
                    begin
                        wait_next = wait_reg - 1'b1;
                        en_next   = 1'b0;
                    end
                    else
                    begin
                        entry_next = init_command(cmd_idx_reg, cfg.function_flags);
                        send_go    = 1'b1;
                        send_step  = '0;
                        phase_next = PH_CMD_SEND;
                    end
                end
                PH_CMD_SEND:
                begin
                    send_go = 1'b1;
                    if (send_last)
                    begin
                        if (cmd_idx_reg == INIT_CMD_LAST)
                        begin
                            phase_next = PH_Q_WAIT;
                        end
                        else
                        begin
                            cmd_idx_next = cmd_idx_reg + 1'b1;
                            phase_next   = PH_CMD_GAP;
                        end
                    end
                end
                PH_Q_WAIT:
                begin
                    if (wait_reg != '0)
                    begin
                        wait_next = wait_reg - 1'b1;
                        en_next   = 1'b0;
                    end
                    else if (queue_empty)
                    begin
                        en_next = 1'b0;
                    end
                    else
                    begin
                        pop        = 1'b1;
                        entry_next = head;
                        send_go    = 1'b1;
                        send_step  = '0;
                        phase_next = PH_Q_SEND;
                    end
                end
                PH_Q_SEND:
                begin
                    send_go = 1'b1;
                    if (send_last)
                    begin
                        phase_next = PH_Q_WAIT;
                    end
                end
                default:
                begin
                    phase_next = PH_Q_WAIT;
                    wait_next  = '0;
                    en_next    = 1'b0;
                end
            endcase

            // Byte transfer: high nibble with an enable pulse, then the low nibble.
            if (send_go)
            begin
                unique case (send_step)
                    2'd0:
                    begin
                        rs_next       = entry_next.is_data;
                        d_next        = entry_next.value[7:4];
                        en_next       = 1'b1;
                        nib_step_next = 2'd1;
                    end
                    2'd1:
                    begin
                        en_next       = 1'b0;
                        nib_step_next = 2'd2;
                    end
                    2'd2:
                    begin
                        d_next        = entry_next.value[3:0];
                        en_next       = 1'b1;
                        nib_step_next = 2'd3;
                    end
                    default:
                    begin
                        en_next       = 1'b0;
                        nib_step_next = 2'd0;
                        wait_next     = entry_next.long_wait ? cfg.long_cmd_wait
                                                             : cfg.short_wait;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_PWR;
            wait_reg     <= POWER_UP_WAIT_RST;
            repeats_reg  <= '0;
            cmd_idx_reg  <= '0;
            nib_step_reg <= '0;
            entry_reg    <= '0;
            rs_reg       <= 1'b0;
            en_reg       <= 1'b0;
            d_reg        <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            wait_reg     <= wait_next;
            repeats_reg  <= repeats_next;
            cmd_idx_reg  <= cmd_idx_next;
            nib_step_reg <= nib_step_next;
            entry_reg    <= entry_next;
            rs_reg       <= rs_next;
            en_reg       <= en_next;
            d_reg        <= d_next;
        end
    end

    assign result.reg_select  = rs_next;
    assign result.enable_pin  = en_next;
    assign result.data_nibble = d_next;
    assign result.init_done   = (phase_next == PH_Q_WAIT) || (phase_next == PH_Q_SEND);
    assign result.pop         = pop;

endmodule

@@ rtl/char_lcd_nibble_interface.sv @@
// Character LCD controller for the 4-bit bus (RS, EN, D4..D7).
// The input channel (in_valid, in_stall) carries one beat per item: a tick
// that advances the controller by one time unit and updates the pins, or an
// enqueue of a command or data byte into the internal queue.
// Every input beat yields exactly one output beat (out_valid, out_stall) with
// the pin levels, init_done, queue_full and enqueue_dropped after that item.
// Each item passes through one input register, then one result register.
// Throughput is one beat per cycle unless the receiver stalls; the queue memory
// takes one write and one registered read per cycle and so sets no lower rate.
// After reset the controller waits POWER_UP_WAIT_RST ticks, sends the 4-bit wakeup
// nibbles and the four init commands, and only then drains the queue.
// Queued bytes go out high nibble first, each followed by a short or long wait.
// An enqueue to a full queue is dropped and flagged in its result.
// When the receiver stalls, the result register holds and the input register
// fills; in_stall rises only once both are occupied.
// Configuration writes take effect the next time the affected wait is loaded; power_up_wait is never loaded.
module char_lcd_nibble_interface
    import clni_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   opcode,
    input  logic [7:0]             byte_value,
    input  logic                   is_data,
    input  logic                   long_wait,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   reg_select,
    output logic                   enable_pin,
    output logic [3:0]             data_nibble,
    output logic                   init_done,
    output logic                   queue_full,
    output logic                   enqueue_dropped,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t         cfg;
    fifo_status_t fifo_status;
    entry_t       fifo_head;
    entry_t       item_entry;
    seq_out_t     seq_result;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic       opcode_reg;
    entry_t     entry_reg;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic       rs_reg;
    logic       en_reg;
    logic [3:0] d_reg;
    logic       init_done_reg;
    logic       queue_full_reg;
    logic       dropped_reg;

    logic out_ready;
    logic fire;
    logic accept;
    logic is_enqueue;
    logic is_tick;
    logic push;
    logic drop;

    assign out_ready  = !out_valid_reg || !out_stall;
    assign fire       = in_valid_reg && out_ready;
    assign in_stall   = in_valid_reg && !out_ready;
    assign accept     = in_valid && !in_stall;
    assign is_enqueue = (opcode_reg == OP_ENQUEUE);
    assign is_tick    = (opcode_reg == OP_TICK);
    assign drop       = is_enqueue && fifo_status.full;
    assign push       = fire && is_enqueue && !fifo_status.full;

    assign item_entry.long_wait = long_wait;
    assign item_entry.is_data   = is_data;
    assign item_entry.value     = byte_value;

    clni_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    clni_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (entry_reg),
        .pop    (seq_result.pop),
        .head   (fifo_head),
        .status (fifo_status)
    );

    clni_seq u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (fire && is_tick),
        .cfg         (cfg),
        .head        (fifo_head),
        .queue_empty (fifo_status.empty),
        .result      (seq_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg && out_stall;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            rs_reg         <= 1'b0;
            en_reg         <= 1'b0;
            d_reg          <= '0;
            init_done_reg  <= 1'b0;
            queue_full_reg <= 1'b0;
            dropped_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                rs_reg         <= seq_result.reg_select;
                en_reg         <= seq_result.enable_pin;
                d_reg          <= seq_result.data_nibble;
                init_done_reg  <= seq_result.init_done;
                queue_full_reg <= fifo_status.full_next;
                dropped_reg    <= drop;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg <= opcode;
            entry_reg  <= item_entry;
        end
    end

    assign out_valid       = out_valid_reg;
    assign reg_select      = rs_reg;
    assign enable_pin      = en_reg;
    assign data_nibble     = d_reg;
    assign init_done       = init_done_reg;
    assign queue_full      = queue_full_reg;
    assign enqueue_dropped = dropped_reg;

    a_tick_never_drops: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_tick |=> !enqueue_dropped)
        else $error("tick result flagged as dropped enqueue");

    a_full_tracks_fifo: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (queue_full == fifo_status.full))
        else $error("queue_full result disagrees with queue state");

    a_enable_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_tick && enable_pin |=> !enable_pin)
        else $error("enable pulse lasted more than one tick");

    a_init_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        init_done |=> init_done)
        else $error("init_done fell after being set");

endmodule
